### hw/rtl/assert_macros.svh
// Assertion macros for the concurrent checks in the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

### hw/rtl/qrm_pkg.sv
// Constants shared by the quaternion to rotation matrix pipeline.
package qrm_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // Component products formed in the first stage.
    localparam int NUM_PRODS = 10;
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_WW = 3;
    localparam int P_XY = 4;
    localparam int P_XZ = 5;
    localparam int P_YZ = 6;
    localparam int P_WX = 7;
    localparam int P_WY = 8;
    localparam int P_WZ = 9;

    // Matrix entries, row major.
    localparam int NUM_ELEMS = 9;
    localparam int ELEM_R1C1 = 0;
    localparam int ELEM_R1C2 = 1;
    localparam int ELEM_R1C3 = 2;
    localparam int ELEM_R2C1 = 3;
    localparam int ELEM_R2C2 = 4;
    localparam int ELEM_R2C3 = 5;
    localparam int ELEM_R3C1 = 6;
    localparam int ELEM_R3C2 = 7;
    localparam int ELEM_R3C3 = 8;

endpackage

### hw/rtl/qrm_if.sv
// Valid/ready channel interfaces for quaternion items and matrix items.
interface qrm_quat_if #(
    parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
    logic signed [DATA_WIDTH-1:0] quat_w;

    modport source (output valid, output quat_x, output quat_y, output quat_z,
                    output quat_w, input ready);
    modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                    input quat_w, output ready);
endinterface

interface qrm_mat_if #(
    parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] elem_r1c1;
    logic signed [DATA_WIDTH-1:0] elem_r1c2;
    logic signed [DATA_WIDTH-1:0] elem_r1c3;
    logic signed [DATA_WIDTH-1:0] elem_r2c1;
    logic signed [DATA_WIDTH-1:0] elem_r2c2;
    logic signed [DATA_WIDTH-1:0] elem_r2c3;
    logic signed [DATA_WIDTH-1:0] elem_r3c1;
    logic signed [DATA_WIDTH-1:0] elem_r3c2;
    logic signed [DATA_WIDTH-1:0] elem_r3c3;
    logic                         zero_norm;

    modport source (output valid, output elem_r1c1, output elem_r1c2, output elem_r1c3,
                    output elem_r2c1, output elem_r2c2, output elem_r2c3,
                    output elem_r3c1, output elem_r3c2, output elem_r3c3,
                    output zero_norm, input ready);
    modport sink   (input valid, input elem_r1c1, input elem_r1c2, input elem_r1c3,
                    input elem_r2c1, input elem_r2c2, input elem_r2c3,
                    input elem_r3c1, input elem_r3c2, input elem_r3c3,
                    input zero_norm, output ready);
endinterface

### hw/rtl/quaternion_to_rotation_matrix_top.sv
// Quaternion to 3x3 rotation matrix converter, fully pipelined.
//
// The quat channel takes one quaternion (x, y, z, w), signed fixed point with
// FRAC_BITS fraction bits, of any length. The matrix channel returns the
// nine entries of the equivalent rotation matrix, rounded to nearest with
// ties away from zero and saturated, plus zero_norm for an all-zero
// quaternion, in which case the identity matrix is returned.
// The pipeline has one multiply stage, two stages forming the norm, the
// numerators and their signs and magnitudes, FRAC_BITS + 1 restoring
// division steps sharing the norm across the nine entries, and one rounding
// stage. Throughput is one item per cycle while matrix.ready holds; every
// stage is a register with its own valid bit, so bubbles are squeezed out
// as items move forward.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
// When the receiver stalls, the result is held on the matrix channel and
// the stages behind it keep filling until they are all occupied; only then
// does quat.ready drop. No item is lost or repeated across a stall.
`include "assert_macros.svh"

module quaternion_to_rotation_matrix_top #(
    parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = qrm_pkg::FRAC_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    qrm_quat_if.sink  quat,
    qrm_mat_if.source matrix
);

    localparam int PW        = 2 * DATA_WIDTH;
    localparam int MW        = 2 * DATA_WIDTH + 1;
    localparam int QW        = FRAC_BITS + 2;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam logic [QW-1:0] Q_LIMIT = QW'(1) << (FRAC_BITS + 1);

    logic                 prod_valid;
    logic                 prod_ready;
    logic signed [PW-1:0] prod [qrm_pkg::NUM_PRODS];

    logic [DIV_STEPS:0]            div_valid;
    logic [DIV_STEPS:0]            div_ready;
    logic [MW-1:0]                 div_norm [DIV_STEPS+1];
    logic [DIV_STEPS:0]            div_zn;
    logic [qrm_pkg::NUM_ELEMS-1:0] div_neg  [DIV_STEPS+1];
    logic [MW-1:0]                 div_rem  [DIV_STEPS+1][qrm_pkg::NUM_ELEMS];
    logic [QW-1:0]                 div_quot [DIV_STEPS+1][qrm_pkg::NUM_ELEMS];

    logic signed [DATA_WIDTH-1:0] elem [qrm_pkg::NUM_ELEMS];

    logic off_diag_zero;
    logic diag_equal;

    qrm_product #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_product (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (quat.valid),
        .up_ready (quat.ready),
        .x        (quat.quat_x),
        .y        (quat.quat_y),
        .z        (quat.quat_z),
        .w        (quat.quat_w),
        .dn_valid (prod_valid),
        .dn_ready (prod_ready),
        .prod     (prod)
    );

    qrm_combine #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_combine (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prod_valid),
        .up_ready (prod_ready),
        .prod     (prod),
        .dn_valid (div_valid[0]),
        .dn_ready (div_ready[0]),
        .norm     (div_norm[0]),
        .zn       (div_zn[0]),
        .neg      (div_neg[0]),
        .rem      (div_rem[0]),
        .quot     (div_quot[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        qrm_div_stage #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_div_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (div_valid[i]),
            .up_ready (div_ready[i]),
            .up_norm  (div_norm[i]),
            .up_zn    (div_zn[i]),
            .up_neg   (div_neg[i]),
            .up_rem   (div_rem[i]),
            .up_quot  (div_quot[i]),
            .dn_valid (div_valid[i+1]),
            .dn_ready (div_ready[i+1]),
            .dn_norm  (div_norm[i+1]),
            .dn_zn    (div_zn[i+1]),
            .dn_neg   (div_neg[i+1]),
            .dn_rem   (div_rem[i+1]),
            .dn_quot  (div_quot[i+1])
        );
    end

    qrm_round #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (div_valid[DIV_STEPS]),
        .up_ready  (div_ready[DIV_STEPS]),
        .up_zn     (div_zn[DIV_STEPS]),
        .up_neg    (div_neg[DIV_STEPS]),
        .up_quot   (div_quot[DIV_STEPS]),
        .dn_valid  (matrix.valid),
        .dn_ready  (matrix.ready),
        .elem      (elem),
        .zero_norm (matrix.zero_norm)
    );

    assign matrix.elem_r1c1 = elem[qrm_pkg::ELEM_R1C1];
    assign matrix.elem_r1c2 = elem[qrm_pkg::ELEM_R1C2];
    assign matrix.elem_r1c3 = elem[qrm_pkg::ELEM_R1C3];
    assign matrix.elem_r2c1 = elem[qrm_pkg::ELEM_R2C1];
    assign matrix.elem_r2c2 = elem[qrm_pkg::ELEM_R2C2];
    assign matrix.elem_r2c3 = elem[qrm_pkg::ELEM_R2C3];
    assign matrix.elem_r3c1 = elem[qrm_pkg::ELEM_R3C1];
    assign matrix.elem_r3c2 = elem[qrm_pkg::ELEM_R3C2];
    assign matrix.elem_r3c3 = elem[qrm_pkg::ELEM_R3C3];

    assign off_diag_zero = (matrix.elem_r1c2 == '0) && (matrix.elem_r1c3 == '0) &&
                           (matrix.elem_r2c1 == '0) && (matrix.elem_r2c3 == '0) &&
                           (matrix.elem_r3c1 == '0) && (matrix.elem_r3c2 == '0);
    assign diag_equal    = (matrix.elem_r1c1 == matrix.elem_r2c2) &&
                           (matrix.elem_r2c2 == matrix.elem_r3c3);

    // With the output register empty, every stage behind it can move, so
    // the input side must be open.
    `ASSERT_IMPLIES(a_ready_when_drained, clk, rst_n, !matrix.valid, quat.ready)

    // A zero quaternion yields the identity: equal diagonal, zero elsewhere.
    `ASSERT_IMPLIES(a_identity_on_zero, clk, rst_n, matrix.valid && matrix.zero_norm, off_diag_zero && diag_equal)

    // Numerators never exceed the norm, which bounds the raw quotient.
    `ASSERT_IMPLIES(a_quot_bound, clk, rst_n, div_valid[DIV_STEPS] && !div_zn[DIV_STEPS], div_quot[DIV_STEPS][qrm_pkg::ELEM_R1C1] <= Q_LIMIT)

    // An item handed to the rounding stage shows up on the output next cycle.
    `ASSERT_NEXT(a_round_load, clk, rst_n, div_valid[DIV_STEPS] && div_ready[DIV_STEPS], matrix.valid)

endmodule

### hw/rtl/qrm_product.sv
// First pipeline stage: the ten component products of the quaternion.
module qrm_product #(
    parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  logic signed [DATA_WIDTH-1:0]   x,
    input  logic signed [DATA_WIDTH-1:0]   y,
    input  logic signed [DATA_WIDTH-1:0]   z,
    input  logic signed [DATA_WIDTH-1:0]   w,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output logic signed [2*DATA_WIDTH-1:0] prod [qrm_pkg::NUM_PRODS]
);

    localparam int PW = 2 * DATA_WIDTH;

    logic                 valid_reg;
    logic signed [PW-1:0] prod_reg  [qrm_pkg::NUM_PRODS];
    logic signed [PW-1:0] prod_next [qrm_pkg::NUM_PRODS];

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign prod     = prod_reg;

    always_comb
    begin
        prod_next[qrm_pkg::P_XX] = PW'(x) * PW'(x);
        prod_next[qrm_pkg::P_YY] = PW'(y) * PW'(y);
        prod_next[qrm_pkg::P_ZZ] = PW'(z) * PW'(z);
        prod_next[qrm_pkg::P_WW] = PW'(w) * PW'(w);
        prod_next[qrm_pkg::P_XY] = PW'(x) * PW'(y);
        prod_next[qrm_pkg::P_XZ] = PW'(x) * PW'(z);
        prod_next[qrm_pkg::P_YZ] = PW'(y) * PW'(z);
        prod_next[qrm_pkg::P_WX] = PW'(w) * PW'(x);
        prod_next[qrm_pkg::P_WY] = PW'(w) * PW'(y);
        prod_next[qrm_pkg::P_WZ] = PW'(w) * PW'(z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

### hw/rtl/qrm_combine.sv
// Second and third stages: norm and signed numerators, then sign, magnitude
// and the integer quotient bit of each entry.
module qrm_combine #(
    parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = qrm_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  logic signed [2*DATA_WIDTH-1:0] prod [qrm_pkg::NUM_PRODS],
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output logic [2*DATA_WIDTH:0]          norm,
    output logic                           zn,
    output logic [qrm_pkg::NUM_ELEMS-1:0]  neg,
    output logic [2*DATA_WIDTH:0]          rem  [qrm_pkg::NUM_ELEMS],
    output logic [FRAC_BITS+1:0]           quot [qrm_pkg::NUM_ELEMS]
);

    localparam int NW = 2 * DATA_WIDTH + 2;
    localparam int MW = 2 * DATA_WIDTH + 1;
    localparam int QW = FRAC_BITS + 2;

    // Sum stage.
    logic                 sum_valid_reg;
    logic                 sum_ready;
    logic [MW-1:0]        sum_norm_reg;
    logic [MW-1:0]        sum_norm_next;
    logic signed [NW-1:0] num_reg  [qrm_pkg::NUM_ELEMS];
    logic signed [NW-1:0] num_next [qrm_pkg::NUM_ELEMS];
    logic signed [NW-1:0] pxx, pyy, pzz, pww, pxy, pxz, pyz, pwx, pwy, pwz;
    logic signed [NW-1:0] norm_sum;

    // Magnitude stage.
    logic                          mag_valid_reg;
    logic                          mag_ready;
    logic [MW-1:0]                 norm_reg;
    logic                          zn_reg;
    logic                          zn_next;
    logic [qrm_pkg::NUM_ELEMS-1:0] neg_reg;
    logic [qrm_pkg::NUM_ELEMS-1:0] neg_next;
    logic [MW-1:0]                 rem_reg   [qrm_pkg::NUM_ELEMS];
    logic [MW-1:0]                 rem_next  [qrm_pkg::NUM_ELEMS];
    logic [QW-1:0]                 quot_reg  [qrm_pkg::NUM_ELEMS];
    logic [QW-1:0]                 quot_next [qrm_pkg::NUM_ELEMS];
    logic signed [NW-1:0]          abs_val   [qrm_pkg::NUM_ELEMS];
    logic [MW-1:0]                 mag       [qrm_pkg::NUM_ELEMS];
    logic [qrm_pkg::NUM_ELEMS-1:0] int_bit;

    assign mag_ready = !mag_valid_reg || dn_ready;
    assign sum_ready = !sum_valid_reg || mag_ready;
    assign up_ready  = sum_ready;
    assign dn_valid  = mag_valid_reg;
    assign norm      = norm_reg;
    assign zn        = zn_reg;
    assign neg       = neg_reg;
    assign rem       = rem_reg;
    assign quot      = quot_reg;

    assign pxx = NW'(prod[qrm_pkg::P_XX]);
    assign pyy = NW'(prod[qrm_pkg::P_YY]);
    assign pzz = NW'(prod[qrm_pkg::P_ZZ]);
    assign pww = NW'(prod[qrm_pkg::P_WW]);
    assign pxy = NW'(prod[qrm_pkg::P_XY]);
    assign pxz = NW'(prod[qrm_pkg::P_XZ]);
    assign pyz = NW'(prod[qrm_pkg::P_YZ]);
    assign pwx = NW'(prod[qrm_pkg::P_WX]);
    assign pwy = NW'(prod[qrm_pkg::P_WY]);
    assign pwz = NW'(prod[qrm_pkg::P_WZ]);

    // The squared norm is non-negative and never exceeds 2^(2*DATA_WIDTH).
    assign norm_sum      = pxx + pyy + pzz + pww;
    assign sum_norm_next = norm_sum[MW-1:0];

    always_comb
    begin
        num_next[qrm_pkg::ELEM_R1C1] = pww + pxx - pyy - pzz;
        num_next[qrm_pkg::ELEM_R2C2] = pww + pyy - pxx - pzz;
        num_next[qrm_pkg::ELEM_R3C3] = pww + pzz - pxx - pyy;
        num_next[qrm_pkg::ELEM_R1C2] = (pxy + pwz) <<< 1;
        num_next[qrm_pkg::ELEM_R1C3] = (pxz - pwy) <<< 1;
        num_next[qrm_pkg::ELEM_R2C1] = (pxy - pwz) <<< 1;
        num_next[qrm_pkg::ELEM_R2C3] = (pyz + pwx) <<< 1;
        num_next[qrm_pkg::ELEM_R3C1] = (pxz + pwy) <<< 1;
        num_next[qrm_pkg::ELEM_R3C2] = (pyz - pwx) <<< 1;
    end

    // Every numerator is bounded by the norm in magnitude, so the integer
    // quotient bit is set only when the two are equal.
    always_comb
    begin
        zn_next = (sum_norm_reg == '0);
        for (int k = 0; k < qrm_pkg::NUM_ELEMS; k++)
        begin
            neg_next[k]  = num_reg[k][NW-1];
            abs_val[k]   = neg_next[k] ? -num_reg[k] : num_reg[k];
            mag[k]       = abs_val[k][MW-1:0];
            int_bit[k]   = (mag[k] == sum_norm_reg);
            rem_next[k]  = int_bit[k] ? '0 : mag[k];
            quot_next[k] = {{(QW-1){1'b0}}, int_bit[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            mag_valid_reg <= 1'b0;
        end
        else
        begin
            if (sum_ready)
            begin
                sum_valid_reg <= up_valid;
            end
            if (mag_ready)
            begin
                mag_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && sum_ready)
        begin
            sum_norm_reg <= sum_norm_next;
            num_reg      <= num_next;
        end
        if (sum_valid_reg && mag_ready)
        begin
            norm_reg <= sum_norm_reg;
            zn_reg   <= zn_next;
            neg_reg  <= neg_next;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

endmodule

### hw/rtl/qrm_div_stage.sv
// One restoring division step for all nine entries against the shared norm.
module qrm_div_stage #(
    parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = qrm_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [2*DATA_WIDTH:0]         up_norm,
    input  logic                          up_zn,
    input  logic [qrm_pkg::NUM_ELEMS-1:0] up_neg,
    input  logic [2*DATA_WIDTH:0]         up_rem  [qrm_pkg::NUM_ELEMS],
    input  logic [FRAC_BITS+1:0]          up_quot [qrm_pkg::NUM_ELEMS],
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output logic [2*DATA_WIDTH:0]         dn_norm,
    output logic                          dn_zn,
    output logic [qrm_pkg::NUM_ELEMS-1:0] dn_neg,
    output logic [2*DATA_WIDTH:0]         dn_rem  [qrm_pkg::NUM_ELEMS],
    output logic [FRAC_BITS+1:0]          dn_quot [qrm_pkg::NUM_ELEMS]
);

    localparam int MW = 2 * DATA_WIDTH + 1;
    localparam int QW = FRAC_BITS + 2;

    logic                          valid_reg;
    logic [MW-1:0]                 norm_reg;
    logic                          zn_reg;
    logic [qrm_pkg::NUM_ELEMS-1:0] neg_reg;
    logic [MW-1:0]                 rem_reg   [qrm_pkg::NUM_ELEMS];
    logic [MW-1:0]                 rem_next  [qrm_pkg::NUM_ELEMS];
    logic [QW-1:0]                 quot_reg  [qrm_pkg::NUM_ELEMS];
    logic [QW-1:0]                 quot_next [qrm_pkg::NUM_ELEMS];
    logic [MW:0]                   trial     [qrm_pkg::NUM_ELEMS];
    logic [MW:0]                   diff      [qrm_pkg::NUM_ELEMS];
    logic [qrm_pkg::NUM_ELEMS-1:0] fits;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_norm  = norm_reg;
    assign dn_zn    = zn_reg;
    assign dn_neg   = neg_reg;
    assign dn_rem   = rem_reg;
    assign dn_quot  = quot_reg;

    // The remainder stays below the norm, so the doubled value fits in one
    // extra bit and the restored remainder fits back into MW bits.
    always_comb
    begin
        for (int k = 0; k < qrm_pkg::NUM_ELEMS; k++)
        begin
            trial[k]     = {up_rem[k], 1'b0};
            diff[k]      = trial[k] - {1'b0, up_norm};
            fits[k]      = (trial[k] >= {1'b0, up_norm});
            rem_next[k]  = fits[k] ? diff[k][MW-1:0] : trial[k][MW-1:0];
            quot_next[k] = {up_quot[k][QW-2:0], fits[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            norm_reg <= up_norm;
            zn_reg   <= up_zn;
            neg_reg  <= up_neg;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

endmodule

### hw/rtl/qrm_round.sv
// Last stage: rounding, sign, saturation and the identity result for a
// zero quaternion; its registers are the output register of the block.
module qrm_round #(
    parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = qrm_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic                          up_zn,
    input  logic [qrm_pkg::NUM_ELEMS-1:0] up_neg,
    input  logic [FRAC_BITS+1:0]          up_quot [qrm_pkg::NUM_ELEMS],
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output logic signed [DATA_WIDTH-1:0]  elem [qrm_pkg::NUM_ELEMS],
    output logic                          zero_norm
);

    localparam int QW = FRAC_BITS + 2;
    localparam int RW = FRAC_BITS + 1;
    localparam int SW = ((RW > DATA_WIDTH) ? RW : DATA_WIDTH) + 1;
    localparam logic [SW-1:0] MIN_MAG = SW'(1) << (DATA_WIDTH - 1);
    localparam logic [SW-1:0] MAX_POS = MIN_MAG - SW'(1);
    localparam logic [RW-1:0] ONE_Q   = RW'(1) << FRAC_BITS;
    localparam logic [DATA_WIDTH-1:0] MIN_OUT = DATA_WIDTH'(1) << (DATA_WIDTH - 1);
    localparam logic [DATA_WIDTH-1:0] MAX_OUT = ~MIN_OUT;

    logic                          valid_reg;
    logic                          zero_norm_reg;
    logic [DATA_WIDTH-1:0]         elem_reg  [qrm_pkg::NUM_ELEMS];
    logic [DATA_WIDTH-1:0]         elem_next [qrm_pkg::NUM_ELEMS];
    logic [QW-1:0]                 quot_inc  [qrm_pkg::NUM_ELEMS];
    logic [RW-1:0]                 rounded   [qrm_pkg::NUM_ELEMS];
    logic [SW-1:0]                 mag_ext   [qrm_pkg::NUM_ELEMS];
    logic [SW-1:0]                 neg_ext   [qrm_pkg::NUM_ELEMS];
    logic [qrm_pkg::NUM_ELEMS-1:0] lane_neg;
    logic [qrm_pkg::NUM_ELEMS-1:0] is_diag;

    assign up_ready  = !valid_reg || dn_ready;
    assign dn_valid  = valid_reg;
    assign zero_norm = zero_norm_reg;

    always_comb
    begin
        for (int k = 0; k < qrm_pkg::NUM_ELEMS; k++)
        begin
            elem[k] = $signed(elem_reg[k]);
        end
    end

    // The quotient carries one bit below the output grid; adding one and
    // dropping it rounds half away from zero on the magnitude.
    always_comb
    begin
        for (int k = 0; k < qrm_pkg::NUM_ELEMS; k++)
        begin
            is_diag[k]  = (k == qrm_pkg::ELEM_R1C1) || (k == qrm_pkg::ELEM_R2C2) ||
                          (k == qrm_pkg::ELEM_R3C3);
            quot_inc[k] = up_quot[k] + QW'(1);
            if (up_zn)
            begin
                rounded[k] = is_diag[k] ? ONE_Q : '0;
            end
            else
            begin
                rounded[k] = quot_inc[k][QW-1:1];
            end
            lane_neg[k] = up_neg[k] && !up_zn;
            mag_ext[k]  = SW'(rounded[k]);
            neg_ext[k]  = -mag_ext[k];
            if (lane_neg[k])
            begin
                elem_next[k] = (mag_ext[k] > MIN_MAG) ? MIN_OUT : neg_ext[k][DATA_WIDTH-1:0];
            end
            else
            begin
                elem_next[k] = (mag_ext[k] > MAX_POS) ? MAX_OUT : mag_ext[k][DATA_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            elem_reg      <= elem_next;
            zero_norm_reg <= up_zn;
        end
    end

endmodule
